@@ src/u2a_pkg.sv @@
// shared types, character tables and code point mapping for the utf-8 to ascii transliterator
// no dependencies; imported by every module of the block

package u2a_pkg;

    localparam int CHAR_LIMIT_W = 9;
    localparam logic [CHAR_LIMIT_W-1:0] CHAR_LIMIT_RESET = 9'd511;

    localparam logic [6:0] CH_QMARK = 7'h3F;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_NONE  = 7'h00;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } u2a_in_t;

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       char_valid;
        logic       last_of_run;
        logic       end_of_text;
    } u2a_out_t;

    // one classified byte: leading '?'s, an optional code point, trailing '?'s
    typedef struct packed {
        logic [1:0]  pre_q;
        logic        cp_valid;
        logic [20:0] cp;
        logic [1:0]  post_q;
        logic        end_text;
    } u2a_job_t;

    typedef struct packed {
        logic [3:0][6:0] ch;
        logic [2:0]      len;
    } u2a_map_t;

    // latin-1 supplement and latin extended-a, 0xC0..0x17F
    // '*' no mapping, '1' AE, '2' ae, '3' ss
    localparam logic [8*192-1:0] LATIN_TAB = {
        "AAAAAA1CEEEEIIII", "*NOOOOO*OUUUUY*3", "aaaaaa2ceeeeiiii", "*nooooo*ouuuuy*y",
        "AaAaAaCcCcCcCcDd", "DdEeEeEeEeEe****", "********IiIiIiIi", "****************",
        "***Nn**Nn***OoOo", "****************", "Ss******UuUuUuUu", "********Y****Zz*"
    };

    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] n;
        n = 3'd0;
        if (lead[7:5] == 3'b110)
            n = 3'd2;
        else if (lead[7:4] == 4'b1110)
            n = 3'd3;
        else if (lead[7:3] == 5'b11110)
            n = 3'd4;
        return n;
    endfunction

    function automatic u2a_map_t mk_map(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d,
                                        input logic [2:0] n);
        u2a_map_t m;
        m.ch[0] = a[6:0];
        m.ch[1] = b[6:0];
        m.ch[2] = c[6:0];
        m.ch[3] = d[6:0];
        m.len   = n;
        return m;
    endfunction

    function automatic u2a_map_t cyr_map(input logic [4:0] idx, input logic lower);
        u2a_map_t m;
        unique case (idx)
            5'd0:  m = mk_map("A", "?", "?", "?", 3'd1);
            5'd1:  m = mk_map("B", "?", "?", "?", 3'd1);
            5'd2:  m = mk_map("V", "?", "?", "?", 3'd1);
            5'd3:  m = mk_map("G", "?", "?", "?", 3'd1);
            5'd4:  m = mk_map("D", "?", "?", "?", 3'd1);
            5'd5:  m = mk_map("E", "?", "?", "?", 3'd1);
            5'd6:  m = mk_map("Z", "h", "?", "?", 3'd2);
            5'd7:  m = mk_map("Z", "?", "?", "?", 3'd1);
            5'd8:  m = mk_map("I", "?", "?", "?", 3'd1);
            5'd9:  m = mk_map("Y", "?", "?", "?", 3'd1);
            5'd10: m = mk_map("K", "?", "?", "?", 3'd1);
            5'd11: m = mk_map("L", "?", "?", "?", 3'd1);
            5'd12: m = mk_map("M", "?", "?", "?", 3'd1);
            5'd13: m = mk_map("N", "?", "?", "?", 3'd1);
            5'd14: m = mk_map("O", "?", "?", "?", 3'd1);
            5'd15: m = mk_map("P", "?", "?", "?", 3'd1);
            5'd16: m = mk_map("R", "?", "?", "?", 3'd1);
            5'd17: m = mk_map("S", "?", "?", "?", 3'd1);
            5'd18: m = mk_map("T", "?", "?", "?", 3'd1);
            5'd19: m = mk_map("U", "?", "?", "?", 3'd1);
            5'd20: m = mk_map("F", "?", "?", "?", 3'd1);
            5'd21: m = mk_map("K", "h", "?", "?", 3'd2);
            5'd22: m = mk_map("T", "s", "?", "?", 3'd2);
            5'd23: m = mk_map("C", "h", "?", "?", 3'd2);
            5'd24: m = mk_map("S", "h", "?", "?", 3'd2);
            5'd25: m = mk_map("S", "h", "c", "h", 3'd4);
            5'd26: m = mk_map("?", "?", "?", "?", 3'd0);
            5'd27: m = mk_map("Y", "?", "?", "?", 3'd1);
            5'd28: m = mk_map("?", "?", "?", "?", 3'd0);
            5'd29: m = mk_map("E", "?", "?", "?", 3'd1);
            5'd30: m = mk_map("Y", "u", "?", "?", 3'd2);
            5'd31: m = mk_map("Y", "a", "?", "?", 3'd2);
            default: m = mk_map("?", "?", "?", "?", 3'd1);
        endcase
        // first letter of every entry is upper case
        if (lower && m.len != 3'd0)
            m.ch[0] = m.ch[0] | 7'h20;
        return m;
    endfunction

    function automatic u2a_map_t map_cp(input logic [20:0] cp);
        u2a_map_t   m;
        logic [7:0] li;
        logic [7:0] lpos;
        logic [7:0] lc;
        logic       in_latin;
        m        = mk_map("?", "?", "?", "?", 3'd1);
        li       = 8'(cp[8:0] - 9'h0C0);
        lpos     = 8'd191 - li;
        lc       = LATIN_TAB[{lpos, 3'b000} +: 8];
        in_latin = (cp >= 21'h0000C0) && (cp <= 21'h00017F) && (lc != "*");
        if (cp == 21'h0A || cp == 21'h0D || cp == 21'h09)
            m = mk_map(" ", "?", "?", "?", 3'd1);
        else if (cp >= 21'h20 && cp <= 21'h7E)
            m = mk_map({1'b0, cp[6:0]}, "?", "?", "?", 3'd1);
        else if (in_latin)
        begin
            if (lc == "1")
                m = mk_map("A", "E", "?", "?", 3'd2);
            else if (lc == "2")
                m = mk_map("a", "e", "?", "?", 3'd2);
            else if (lc == "3")
                m = mk_map("s", "s", "?", "?", 3'd2);
            else
                m = mk_map(lc, "?", "?", "?", 3'd1);
        end
        else if (cp >= 21'h000410 && cp <= 21'h00042F)
            m = cyr_map(5'(cp[4:0] - 5'h10), 1'b0);
        else if (cp >= 21'h000430 && cp <= 21'h00044F)
            m = cyr_map(5'(cp[4:0] - 5'h10), 1'b1);
        else if (cp == 21'h000401)
            m = mk_map("E", "?", "?", "?", 3'd1);
        else if (cp == 21'h000451)
            m = mk_map("e", "?", "?", "?", 3'd1);
        else if (cp == 21'h002018 || cp == 21'h002019)
            m = mk_map("'", "?", "?", "?", 3'd1);
        else if (cp == 21'h00201C || cp == 21'h00201D)
            m = mk_map("\"", "?", "?", "?", 3'd1);
        else if (cp == 21'h002013 || cp == 21'h002014)
            m = mk_map("-", "?", "?", "?", 3'd1);
        else if (cp == 21'h002026)
            m = mk_map(".", ".", ".", "?", 3'd3);
        return m;
    endfunction

endpackage

@@ src/u2a_front.sv @@
// front end: utf-8 sequence assembly and byte classification into jobs
// depends on u2a_pkg; feeds u2a_queue

module u2a_front
    import u2a_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  u2a_in_t  in_data,
    input  logic     q_full,
    output logic     push,
    output u2a_job_t job
);

    logic [23:0] seq_reg;
    logic [23:0] seq_next;
    logic [1:0]  pc_reg;
    logic [1:0]  pc_next;

    logic [7:0]  b;
    logic        end_txt;
    logic        is_cont;
    logic [7:0]  lead;
    logic [2:0]  need;
    logic [7:0]  lead_mask;
    logic [7:0]  lm;
    logic [20:0] cp_cont;
    logic        complete;
    logic        consumed;
    logic        bad;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        b       = in_data.text_byte;
        end_txt = in_data.last_byte || (b == 8'h00);
        is_cont = (b[7:6] == 2'b10);

        unique case (pc_reg)
            2'd2:    lead = seq_reg[15:8];
            2'd3:    lead = seq_reg[23:16];
            default: lead = seq_reg[7:0];
        endcase
        need = seq_len(lead);
        unique case (need)
            3'd4:    lead_mask = 8'h07;
            3'd3:    lead_mask = 8'h0F;
            default: lead_mask = 8'h1F;
        endcase
        lm = lead & lead_mask;

        unique case (pc_reg)
            2'd2:    cp_cont = 21'({lm, seq_reg[5:0], b[5:0]});
            2'd3:    cp_cont = {lm[2:0], seq_reg[13:8], seq_reg[5:0], b[5:0]};
            default: cp_cont = 21'({lm, b[5:0]});
        endcase
        complete = (3'({1'b0, pc_reg}) + 3'd1) >= need;

        job      = '0;
        seq_next = seq_reg;
        pc_next  = pc_reg;
        consumed = 1'b0;
        bad      = 1'b0;

        if (pc_reg != 2'd0)
        begin
            if (is_cont)
            begin
                consumed = 1'b1;
                if (complete)
                begin
                    job.cp_valid = 1'b1;
                    job.cp       = cp_cont;
                    seq_next     = '0;
                    pc_next      = 2'd0;
                end
                else
                begin
                    seq_next = {seq_reg[15:0], b};
                    pc_next  = pc_reg + 2'd1;
                end
            end
            else
            begin
                job.pre_q = pc_reg;
                seq_next  = '0;
                pc_next   = 2'd0;
            end
        end

        if (!consumed && b != 8'h00)
        begin
            if (!b[7])
            begin
                job.cp_valid = 1'b1;
                job.cp       = {13'd0, b};
            end
            else if (seq_len(b) != 3'd0)
            begin
                seq_next = {16'd0, b};
                pc_next  = 2'd1;
            end
            else
                bad = 1'b1;
        end

        if (bad)
            job.post_q = 2'd1;
        else if (end_txt)
            job.post_q = pc_next;
        job.end_text = end_txt;

        if (end_txt)
        begin
            seq_next = '0;
            pc_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= '0;
            pc_reg  <= 2'd0;
        end
        else if (push)
        begin
            seq_reg <= seq_next;
            pc_reg  <= pc_next;
        end
    end

endmodule

@@ src/u2a_queue.sv @@
// two-entry job queue between front end and emitter
// depends on u2a_pkg for the job type

module u2a_queue
    import u2a_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  u2a_job_t wr_job,
    output logic     full,
    input  logic     pop,
    output logic     valid,
    output u2a_job_t rd_job
);

    u2a_job_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign rd_job  = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

@@ src/u2a_back.sv @@
// back end: code point mapping, character limit and one-beat-per-character emitter
// depends on u2a_pkg; drains u2a_queue, owns the char_limit register and output register

module u2a_back
    import u2a_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CHAR_LIMIT_W-1:0] cfg_wdata,
    input  logic                    q_valid,
    input  u2a_job_t                q_job,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output u2a_out_t                out_data
);

    logic [CHAR_LIMIT_W-1:0] limit_reg;
    logic [CHAR_LIMIT_W-1:0] emitted_reg;
    logic [CHAR_LIMIT_W-1:0] emitted_next;

    // expanded item
    logic            exp_valid_reg;
    logic            exp_valid_next;
    logic [3:0][6:0] exp_ch_reg;
    logic [2:0]      exp_n_reg;
    logic            exp_end_reg;
    logic [1:0]      idx_reg;
    logic [1:0]      idx_next;

    logic            out_valid_reg;
    logic            out_valid_next;
    u2a_out_t        out_data_reg;
    u2a_out_t        out_data_next;

    u2a_map_t        m;
    logic [2:0]      mlen;
    logic [3:0]      n_sum;
    logic [3:0]      pm_sum;
    logic [2:0]      n_fill;
    logic [3:0][6:0] ch_fill;
    logic [1:0]      mi;

    logic            out_free;
    logic            room;
    logic            emit_char;
    logic            last_char;
    logic            step;
    logic            done;
    logic            exp_take;

    // fill the expanded character list from a queued job
    always_comb
    begin
        m      = map_cp(q_job.cp);
        mlen   = q_job.cp_valid ? m.len : 3'd0;
        pm_sum = 4'({2'b00, q_job.pre_q}) + 4'({1'b0, mlen});
        n_sum  = pm_sum + 4'({2'b00, q_job.post_q});
        n_fill = (n_sum > 4'd4) ? 3'd4 : n_sum[2:0];
        for (int i = 0; i < 4; i++)
        begin
            mi = 2'(i - int'(q_job.pre_q));
            if (4'(i) < 4'({2'b00, q_job.pre_q}))
                ch_fill[i] = CH_QMARK;
            else if (4'(i) < pm_sum)
                ch_fill[i] = m.ch[mi];
            else
                ch_fill[i] = CH_QMARK;
        end
    end

    always_comb
    begin
        out_free  = !out_valid_reg || out_ready;
        room      = emitted_reg < limit_reg;
        emit_char = room && ({1'b0, idx_reg} < exp_n_reg);
        last_char = (3'({1'b0, idx_reg}) + 3'd1 == exp_n_reg)
                    || (emitted_reg + 9'd1 == limit_reg);
        step      = exp_valid_reg && out_free;
        done      = step && (!emit_char || last_char);
        exp_take  = !exp_valid_reg || done;
        pop       = exp_take && q_valid;

        exp_valid_next = exp_take ? q_valid : exp_valid_reg;

        idx_next = idx_reg;
        if (done)
            idx_next = 2'd0;
        else if (step && emit_char)
            idx_next = idx_reg + 2'd1;

        emitted_next = emitted_reg;
        if (step && emit_char)
            emitted_next = emitted_reg + 9'd1;
        if (done && exp_end_reg)
            emitted_next = '0;

        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (step && emit_char)
        begin
            out_valid_next           = 1'b1;
            out_data_next.ascii_char = exp_ch_reg[idx_reg];
            out_data_next.char_valid = 1'b1;
            out_data_next.last_of_run = last_char;
            out_data_next.end_of_text = last_char && exp_end_reg;
        end
        else if (step && exp_end_reg)
        begin
            // empty closing beat
            out_valid_next            = 1'b1;
            out_data_next.ascii_char  = CH_NONE;
            out_data_next.char_valid  = 1'b0;
            out_data_next.last_of_run = 1'b1;
            out_data_next.end_of_text = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= CHAR_LIMIT_RESET;
            emitted_reg   <= '0;
            exp_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            emitted_reg   <= emitted_next;
            exp_valid_reg <= exp_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            exp_ch_reg  <= ch_fill;
            exp_n_reg   <= n_fill;
            exp_end_reg <= q_job.end_text;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_printable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.char_valid |->
            out_data_reg.ascii_char >= 7'h20 && out_data_reg.ascii_char <= 7'h7E)
        else $error("emitted character not printable");

    a_empty_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.char_valid |->
            out_data_reg.last_of_run && out_data_reg.end_of_text)
        else $error("empty beat without end of text");

    a_idx_in_item: assert property (@(posedge clk) disable iff (!rst_n)
        exp_valid_reg && idx_reg != 2'd0 |-> {1'b0, idx_reg} < exp_n_reg)
        else $error("emitter index past item length");

endmodule

@@ src/utf8_to_ascii_transliterator.sv @@
// top level of the utf-8 to printable ascii transliterator
// depends on u2a_pkg, u2a_front, u2a_queue and u2a_back

// Takes one UTF-8 byte per in beat and gives printable ASCII characters, one per out
// beat. Bytes that yield zero or one character each flow at one byte per cycle while
// out_ready stays high; a byte that yields several characters (at most four) holds
// the emitter until it has given them all, and a byte yielding nothing that does not
// end the text still takes its turn in the emitter. The front end assembles sequences
// and pushes a job into a two-entry queue on the same edge as the byte is taken; the
// emitter then takes the job into its expanded-item register, and from there the
// character goes into the output register. in_ready falls only while the queue is full.
// cfg_we writes char_limit, the most characters per text; write it only while the
// block is idle.

module utf8_to_ascii_transliterator
    import u2a_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CHAR_LIMIT_W-1:0] cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  u2a_in_t                 in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output u2a_out_t                out_data
);

    logic     q_full;
    logic     push;
    u2a_job_t wr_job;
    logic     q_valid;
    logic     pop;
    u2a_job_t rd_job;

    u2a_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .job      (wr_job)
    );

    u2a_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .full   (q_full),
        .pop    (pop),
        .valid  (q_valid),
        .rd_job (rd_job)
    );

    u2a_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_job     (rd_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
